// File: rtl/assert_macros.svh
// Assertion macros shared by the power button classifier RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PBPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("pbpc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PBPC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("pbpc assertion failed");

`endif

// File: rtl/pbpc_pkg.sv
// Shared types, constants and helper functions for the power button classifier.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package pbpc_pkg;

  localparam int TIMER_BITS  = 24;
  localparam int FLASH_STEPS = 8;
  localparam int STEP_BITS   = 4;
  localparam int DEB_BITS    = 16;
  localparam int TICK_BITS   = 24;

  typedef logic [TIMER_BITS-1:0] tmr_t;
  typedef logic [STEP_BITS-1:0]  step_t;
  typedef logic [DEB_BITS-1:0]   deb_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_PRESSED_LEVEL = 3'd0,
    CFG_DEBOUNCE      = 3'd1,
    CFG_SHORT_PRESS   = 3'd2,
    CFG_LONG_PRESS    = 3'd3,
    CFG_FLASH_STEP    = 3'd4,
    CFG_INITIAL_MF    = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic                 pressed_level;
    deb_t                 debounce_ticks;
    logic [TICK_BITS-1:0] short_press_ticks;
    logic [TICK_BITS-1:0] long_press_ticks;
    logic [TICK_BITS-1:0] flash_step_ticks;
    logic                 initial_mf;
  } cfg_t;

  // Debounced event handed from the front to the back, one per tick
  typedef struct packed {
    logic change;
    logic level;
  } evt_t;

  typedef enum logic [1:0] {
    LED_GREEN  = 2'd0,
    LED_YELLOW = 2'd1,
    LED_OFF    = 2'd2
  } led_t;

  // Press machine, one-hot
  typedef enum logic [4:0] {
    PH_RELEASE  = 5'b00001,
    PH_PRESS    = 5'b00010,
    PH_PRESS_ON = 5'b00100,
    PH_SHORT    = 5'b01000,
    PH_LONG     = 5'b10000
  } phase_t;

  // Phase codes as seen on the result port
  localparam logic [2:0] PCODE_RELEASE  = 3'd0;
  localparam logic [2:0] PCODE_PRESS    = 3'd1;
  localparam logic [2:0] PCODE_PRESS_ON = 3'd2;
  localparam logic [2:0] PCODE_SHORT    = 3'd3;
  localparam logic [2:0] PCODE_LONG     = 3'd4;

  localparam logic [31:0] TIMER_MASK = 32'((64'd1 << TIMER_BITS) - 64'd1);

  // Saturate a count to the timer width; zero acts as one
  function automatic tmr_t timer_load(input logic [TICK_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w > TIMER_MASK) w = TIMER_MASK;
    if (w == 32'd0) w = 32'd1;
    return tmr_t'(w);
  endfunction

  function automatic led_t mf_color(input logic mf);
    return mf ? LED_YELLOW : LED_GREEN;
  endfunction

  function automatic logic [2:0] phase_code(input phase_t ph);
    logic [2:0] c;
    c = PCODE_RELEASE;
    unique case (ph)
      PH_PRESS:    c = PCODE_PRESS;
      PH_PRESS_ON: c = PCODE_PRESS_ON;
      PH_SHORT:    c = PCODE_SHORT;
      PH_LONG:     c = PCODE_LONG;
      default:     c = PCODE_RELEASE;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/power_button_press_classifier.sv
// Top level of the power button press classifier: configuration registers,
// debounce front, event queue and press back end. Depends on pbpc_pkg.
`timescale 1ns / 1ps

// One input beat is one microsecond tick of the raw button level and yields
// exactly one result beat. The block takes one beat per clock cycle while the
// event queue has room, and each beat reaches the result register through it.
// The debounce front and the press back end are parted by a two-entry event
// queue and the back end ends in a result register, so a stalled result side
// lets two more ticks in before in_ready drops. Configuration writes are
// always taken (cfg_ready is tied high) and must only be made while the block
// is idle. No clearing pass follows reset; the first tick loads the debounced
// level and the initial multi-function bit.
module power_button_press_classifier
  import pbpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_button_raw,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_wake_pulse,
  output logic        out_sleep_pulse,
  output logic        out_mf_toggle_pulse,
  output logic        out_dock_on,
  output logic        out_mf_value,
  output logic [1:0]  out_led_drive,
  output logic [2:0]  out_press_phase
);

  cfg_t cfg_r;
  logic q_push, q_ready, q_pop, q_valid;
  evt_t push_evt, pop_evt;

  assign cfg_ready = 1'b1;
  assign in_ready  = q_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pressed_level     <= 1'b0;
      cfg_r.debounce_ticks    <= DEB_BITS'(30);
      cfg_r.short_press_ticks <= TICK_BITS'(300000);
      cfg_r.long_press_ticks  <= TICK_BITS'(5000000);
      cfg_r.flash_step_ticks  <= TICK_BITS'(150000);
      cfg_r.initial_mf        <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PRESSED_LEVEL: cfg_r.pressed_level     <= cfg_data[0];
        CFG_DEBOUNCE:      cfg_r.debounce_ticks    <= cfg_data[DEB_BITS-1:0];
        CFG_SHORT_PRESS:   cfg_r.short_press_ticks <= cfg_data;
        CFG_LONG_PRESS:    cfg_r.long_press_ticks  <= cfg_data;
        CFG_FLASH_STEP:    cfg_r.flash_step_ticks  <= cfg_data;
        CFG_INITIAL_MF:    cfg_r.initial_mf        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pbpc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_button_raw (in_button_raw),
    .q_ready       (q_ready),
    .q_push        (q_push),
    .q_evt         (push_evt)
  );

  pbpc_evq u_evq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_evt   (push_evt),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_evt    (pop_evt)
  );

  pbpc_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .q_valid             (q_valid),
    .q_evt               (pop_evt),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_wake_pulse      (out_wake_pulse),
    .out_sleep_pulse     (out_sleep_pulse),
    .out_mf_toggle_pulse (out_mf_toggle_pulse),
    .out_dock_on         (out_dock_on),
    .out_mf_value        (out_mf_value),
    .out_led_drive       (out_led_drive),
    .out_press_phase     (out_press_phase)
  );

endmodule

// File: rtl/pbpc_front.sv
// Front end: per-tick debounce of the raw button level, one event per beat.
// Depends on pbpc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pbpc_front
  import pbpc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic in_valid,
  input  logic in_button_raw,
  input  logic q_ready,
  output logic q_push,
  output evt_t q_evt
);

  logic loaded_r, loaded_nxt;
  logic last_raw_r, last_raw_nxt;
  logic stable_r, stable_nxt;
  logic busy_r, busy_nxt;
  deb_t left_r, left_nxt;
  logic last_eff;
  tmr_t deb_load;

  assign q_push = in_valid && q_ready;
  assign deb_load = timer_load(TICK_BITS'(cfg.debounce_ticks));

  // Debounce step for the beat being taken
  always_comb begin
    loaded_nxt   = 1'b1;
    last_eff     = loaded_r ? last_raw_r : in_button_raw;
    last_raw_nxt = last_eff;
    stable_nxt   = loaded_r ? stable_r : in_button_raw;
    busy_nxt     = busy_r;
    left_nxt     = left_r;
    q_evt.change = 1'b0;
    if (in_button_raw != last_eff) begin
      last_raw_nxt = in_button_raw;
      left_nxt     = DEB_BITS'(deb_load);
      busy_nxt     = 1'b1;
    end else if (busy_r) begin
      left_nxt = left_r - DEB_BITS'(1);
      if (left_nxt == '0) begin
        busy_nxt     = 1'b0;
        stable_nxt   = last_eff;
        q_evt.change = 1'b1;
      end
    end
    q_evt.level = stable_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r   <= 1'b0;
      last_raw_r <= 1'b0;
      stable_r   <= 1'b0;
      busy_r     <= 1'b0;
      left_r     <= '0;
    end else if (q_push) begin
      loaded_r   <= loaded_nxt;
      last_raw_r <= last_raw_nxt;
      stable_r   <= stable_nxt;
      busy_r     <= busy_nxt;
      left_r     <= left_nxt;
    end
  end

  // A running debounce count never sits at zero
  `PBPC_ASSERT_IMP(a_busy_nonzero, clk, rst_n, busy_r, (left_r != '0))
  // An event only comes out of a count that was running
  `PBPC_ASSERT_IMP(a_change_from_busy, clk, rst_n, (q_push && q_evt.change), busy_r)

endmodule

// File: rtl/pbpc_evq.sv
// Two-entry event queue between the debounce front and the press back end.
// Depends on pbpc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pbpc_evq
  import pbpc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  evt_t push_evt,
  output logic push_ready,
  input  logic pop,
  output logic pop_valid,
  output evt_t pop_evt
);

  evt_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_evt    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_evt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `PBPC_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, (count_r <= 2'd2))
  `PBPC_ASSERT_IMP(a_ptr_empty, clk, rst_n, (count_r == 2'd0), (wr_ptr_r == rd_ptr_r))
  `PBPC_ASSERT_IMP(a_ptr_full, clk, rst_n, (count_r == 2'd2), (wr_ptr_r == rd_ptr_r))

endmodule

// File: rtl/pbpc_back.sv
// Back end: press timer, press machine, LED flash sequencer and result register.
// Depends on pbpc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pbpc_back
  import pbpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       q_valid,
  input  evt_t       q_evt,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_wake_pulse,
  output logic       out_sleep_pulse,
  output logic       out_mf_toggle_pulse,
  output logic       out_dock_on,
  output logic       out_mf_value,
  output logic [1:0] out_led_drive,
  output logic [2:0] out_press_phase
);

  logic   loaded_r;
  phase_t phase_r, phase_nxt;
  logic   armed_r, armed_nxt;
  tmr_t   press_left_r, press_left_nxt;
  logic   powered_r, powered_nxt;
  logic   mf_r, mf_nxt;
  led_t   led_r, led_nxt;
  step_t  step_r, step_nxt;
  tmr_t   flash_left_r, flash_left_nxt;

  logic   on_p, off_p, mf_p;
  logic   timeout, released, pressed, to_long;
  tmr_t   short_arm, long_arm, flash_load;

  logic   ov_r;
  logic   o_on_r, o_off_r, o_mf_r, o_dock_r, o_mfv_r;
  led_t   o_led_r;
  phase_t o_phase_r;

  // A beat moves on when the result register is free or being emptied
  assign q_pop = q_valid && (!ov_r || out_ready);

  // Timer reloads
  always_comb begin
    short_arm = timer_load((cfg.short_press_ticks > TICK_BITS'(cfg.debounce_ticks)) ?
                           cfg.short_press_ticks - TICK_BITS'(cfg.debounce_ticks) :
                           TICK_BITS'(1));
    long_arm  = timer_load((cfg.long_press_ticks > cfg.short_press_ticks) ?
                           cfg.long_press_ticks - cfg.short_press_ticks : TICK_BITS'(1));
    flash_load = timer_load(cfg.flash_step_ticks);
  end

  // One tick of press timer, flash sequencer and press machine
  always_comb begin
    mf_nxt         = loaded_r ? mf_r : cfg.initial_mf;
    led_nxt        = loaded_r ? led_r : mf_color(cfg.initial_mf);
    phase_nxt      = phase_r;
    armed_nxt      = armed_r;
    press_left_nxt = press_left_r;
    powered_nxt    = powered_r;
    step_nxt       = step_r;
    flash_left_nxt = flash_left_r;
    on_p           = 1'b0;
    off_p          = 1'b0;
    mf_p           = 1'b0;
    timeout        = 1'b0;
    to_long        = 1'b0;

    // press timer
    if (armed_r) begin
      press_left_nxt = press_left_r - TIMER_BITS'(1);
      if (press_left_nxt == '0) begin
        armed_nxt = 1'b0;
        timeout   = 1'b1;
      end
    end

    // flash sequencer
    if (step_r < STEP_BITS'(FLASH_STEPS)) begin
      flash_left_nxt = flash_left_r - TIMER_BITS'(1);
      if (flash_left_nxt == '0) begin
        led_nxt  = step_r[0] ? mf_color(step_r[2] ? mf_nxt : ~mf_nxt) : LED_OFF;
        step_nxt = step_r + STEP_BITS'(1);
        if (step_nxt < STEP_BITS'(FLASH_STEPS)) flash_left_nxt = flash_load;
      end
    end

    released = q_evt.change && (q_evt.level != cfg.pressed_level);
    pressed  = q_evt.change && (q_evt.level == cfg.pressed_level);

    // press machine
    if (q_evt.change || timeout) begin
      armed_nxt = 1'b0;
      unique case (phase_r)
        PH_PRESS: begin
          if (released) begin
            phase_nxt = PH_RELEASE;
          end else begin
            press_left_nxt = long_arm;
            armed_nxt      = 1'b1;
            if (!powered_r) begin
              powered_nxt = 1'b1;
              on_p        = 1'b1;
              led_nxt     = mf_color(mf_nxt);
              phase_nxt   = PH_PRESS_ON;
            end else begin
              phase_nxt = PH_SHORT;
            end
          end
        end
        PH_PRESS_ON: begin
          if (released) phase_nxt = PH_RELEASE;
          else to_long = 1'b1;
        end
        PH_SHORT: begin
          if (released) begin
            phase_nxt   = PH_RELEASE;
            powered_nxt = 1'b0;
            off_p       = 1'b1;
            led_nxt     = LED_OFF;
          end else begin
            to_long = 1'b1;
          end
        end
        PH_LONG: begin
          if (released) phase_nxt = PH_RELEASE;
        end
        default: begin
          phase_nxt = PH_RELEASE;
          if (pressed) begin
            phase_nxt      = PH_PRESS;
            press_left_nxt = short_arm;
            armed_nxt      = 1'b1;
          end
        end
      endcase
      // long hold: toggle and run flash step zero, which blanks the LED
      if (to_long) begin
        phase_nxt      = PH_LONG;
        mf_nxt         = ~mf_nxt;
        mf_p           = 1'b1;
        led_nxt        = LED_OFF;
        step_nxt       = STEP_BITS'(1);
        flash_left_nxt = flash_load;
      end
    end
  end

  // Working state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r     <= 1'b0;
      phase_r      <= PH_RELEASE;
      armed_r      <= 1'b0;
      press_left_r <= '0;
      powered_r    <= 1'b1;
      mf_r         <= 1'b0;
      led_r        <= LED_GREEN;
      step_r       <= STEP_BITS'(FLASH_STEPS);
      flash_left_r <= '0;
    end else if (q_pop) begin
      loaded_r     <= 1'b1;
      phase_r      <= phase_nxt;
      armed_r      <= armed_nxt;
      press_left_r <= press_left_nxt;
      powered_r    <= powered_nxt;
      mf_r         <= mf_nxt;
      led_r        <= led_nxt;
      step_r       <= step_nxt;
      flash_left_r <= flash_left_nxt;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (q_pop) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      o_on_r    <= on_p;
      o_off_r   <= off_p;
      o_mf_r    <= mf_p;
      o_dock_r  <= powered_nxt;
      o_mfv_r   <= mf_nxt;
      o_led_r   <= led_nxt;
      o_phase_r <= phase_nxt;
    end
  end

  assign out_valid           = ov_r;
  assign out_wake_pulse      = o_on_r;
  assign out_sleep_pulse     = o_off_r;
  assign out_mf_toggle_pulse = o_mf_r;
  assign out_dock_on         = o_dock_r;
  assign out_mf_value        = o_mfv_r;
  assign out_led_drive       = o_led_r;
  assign out_press_phase     = phase_code(o_phase_r);

  `PBPC_ASSERT_IMP(a_armed_nonzero, clk, rst_n, armed_r, (press_left_r != '0))
  `PBPC_ASSERT_IMP(a_flash_nonzero, clk, rst_n, (step_r < STEP_BITS'(FLASH_STEPS)),
                   (flash_left_r != '0))
  `PBPC_ASSERT_IMP(a_pulse_excl, clk, rst_n, ov_r, ($onehot0({o_on_r, o_off_r, o_mf_r})))
  `PBPC_ASSERT_NXT(a_wake_state, clk, rst_n, (q_pop && on_p), (powered_r && ov_r))

endmodule

// File: tb/tb_power_button_press_classifier.sv
// Self-checking testbench for the power button press classifier.
// Predicts each result beat from the debounce, press and flash rules; depends on pbpc_pkg.
`timescale 1ns / 1ps

module tb_power_button_press_classifier
  import pbpc_pkg::*;
();

  localparam int          CYCLE_LIMIT  = 300000;
  localparam int          LATENCY_PAD  = 8;
  localparam int          HOLD_CYCLES  = 150;
  // register slots that decode to nothing
  localparam logic [2:0]  CFG_UNMAPPED_LO = 3'd6;
  localparam logic [2:0]  CFG_UNMAPPED_HI = 3'd7;
  // opening press pattern, sent MSB first
  localparam logic [23:0] OPENING_RAW  = 24'b0111_0011_1111_1110_1011_0010;

  typedef struct packed {
    logic       wake;
    logic       sleep;
    logic       mf_toggle;
    logic       dock_on;
    logic       mf_value;
    logic [1:0] led_drive;
    logic [2:0] press_phase;
  } press_result_t;

  // Tracks the classifier state and holds the result beats still due
  class press_scoreboard;
    logic        pressed_lvl;
    logic [15:0] deb_ticks;
    logic [23:0] short_ticks;
    logic [23:0] long_ticks;
    logic [23:0] step_ticks;
    logic        init_mf;

    bit          primed;
    logic [2:0]  phase;
    logic        last_raw;
    logic        stable;
    tmr_t        deb_left;
    bit          deb_busy;
    tmr_t        press_left;
    bit          press_armed;
    logic        dock;
    logic        mf;
    led_t        led;
    step_t       flash_step;
    tmr_t        flash_left;

    press_result_t pending_results[$];
    int            failures;

    function new();
      pressed_lvl = 1'b0;
      deb_ticks   = 16'd30;
      short_ticks = 24'd300000;
      long_ticks  = 24'd5000000;
      step_ticks  = 24'd150000;
      init_mf     = 1'b0;
      primed      = 0;
      phase       = PCODE_RELEASE;
      last_raw    = 1'b0;
      stable      = 1'b0;
      deb_left    = '0;
      deb_busy    = 0;
      press_left  = '0;
      press_armed = 0;
      dock        = 1'b1;
      mf          = 1'b0;
      led         = LED_GREEN;
      flash_step  = step_t'(FLASH_STEPS);
      flash_left  = '0;
      failures    = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] data);
      case (idx)
        CFG_PRESSED_LEVEL: pressed_lvl = data[0];
        CFG_DEBOUNCE:      deb_ticks   = data[15:0];
        CFG_SHORT_PRESS:   short_ticks = data;
        CFG_LONG_PRESS:    long_ticks  = data;
        CFG_FLASH_STEP:    step_ticks  = data;
        CFG_INITIAL_MF:    init_mf     = data[0];
        default: ;
      endcase
    endfunction

    // saturate to the timer width, zero counts as one
    function tmr_t clamp_count(logic [31:0] ticks);
      logic [31:0] v;
      v = (ticks > TIMER_MASK) ? TIMER_MASK : ticks;
      return (v == 32'd0) ? tmr_t'(1) : tmr_t'(v);
    endfunction

    function void arm_press_timer(logic [31:0] hi_ticks, logic [31:0] lo_ticks);
      press_left  = clamp_count((hi_ticks > lo_ticks) ? hi_ticks - lo_ticks : 32'd1);
      press_armed = 1;
    endfunction

    // one flash step: odd steps light, upper half shows the new color
    function void advance_flash();
      logic hue;
      hue = flash_step[2] ? mf : ~mf;
      led = flash_step[0] ? (hue ? LED_YELLOW : LED_GREEN) : LED_OFF;
      flash_step = flash_step + 4'd1;
      if (flash_step < FLASH_STEPS) flash_left = clamp_count(32'(step_ticks));
    endfunction

    // accepted tick: advance state and queue the result beat it yields
    function void note_tick(logic raw);
      press_result_t r;
      logic chg, tmo, rel, prs, to_long;
      r = '0;
      chg = 1'b0;
      tmo = 1'b0;
      to_long = 1'b0;

      // first tick seeds the levels and the mf bit
      if (!primed) begin
        primed   = 1;
        last_raw = raw;
        stable   = raw;
        mf       = init_mf;
        led      = mf ? LED_YELLOW : LED_GREEN;
      end

      // debounce
      if (raw != last_raw) begin
        last_raw = raw;
        deb_left = clamp_count(32'(deb_ticks));
        deb_busy = 1;
      end else if (deb_busy) begin
        deb_left = deb_left - 1'b1;
        if (deb_left == '0) begin
          deb_busy = 0;
          stable   = last_raw;
          chg      = 1'b1;
        end
      end

      // press timer
      if (press_armed) begin
        press_left = press_left - 1'b1;
        if (press_left == '0) begin
          press_armed = 0;
          tmo = 1'b1;
        end
      end

      // flash sequence runs regardless of power
      if (flash_step < FLASH_STEPS) begin
        flash_left = flash_left - 1'b1;
        if (flash_left == '0) advance_flash();
      end

      // press machine; a change event wins over a timer expiry
      if (chg || tmo) begin
        rel = chg && (stable != pressed_lvl);
        prs = chg && (stable == pressed_lvl);
        press_armed = 0;
        case (phase)
          PCODE_PRESS: begin
            if (rel) begin
              phase = PCODE_RELEASE;
            end else begin
              arm_press_timer(32'(long_ticks), 32'(short_ticks));
              if (!dock) begin
                dock = 1'b1;
                r.wake = 1'b1;
                led = mf ? LED_YELLOW : LED_GREEN;
                phase = PCODE_PRESS_ON;
              end else begin
                phase = PCODE_SHORT;
              end
            end
          end
          PCODE_PRESS_ON: begin
            if (rel) phase = PCODE_RELEASE;
            else to_long = 1'b1;
          end
          PCODE_SHORT: begin
            if (rel) begin
              phase = PCODE_RELEASE;
              dock = 1'b0;
              r.sleep = 1'b1;
              led = LED_OFF;
            end else begin
              to_long = 1'b1;
            end
          end
          PCODE_LONG: begin
            if (rel) phase = PCODE_RELEASE;
          end
          default: begin
            phase = PCODE_RELEASE;
            if (prs) begin
              phase = PCODE_PRESS;
              arm_press_timer(32'(short_ticks), 32'(deb_ticks));
            end
          end
        endcase
        if (to_long) begin
          phase = PCODE_LONG;
          mf = ~mf;
          r.mf_toggle = 1'b1;
          flash_step = '0;
          advance_flash();
        end
      end

      r.dock_on     = dock;
      r.mf_value    = mf;
      r.led_drive   = led;
      r.press_phase = phase;
      pending_results.push_back(r);
    endfunction

    function void compare_field(string field, logic [2:0] want, logic [2:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        failures++;
      end
    endfunction

    function void check_result(press_result_t got);
      press_result_t want;
      if (pending_results.size() == 0) begin
        $error("result beat with no tick pending");
        failures++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("wake_pulse", 3'(want.wake), 3'(got.wake));
      compare_field("sleep_pulse", 3'(want.sleep), 3'(got.sleep));
      compare_field("mf_toggle_pulse", 3'(want.mf_toggle), 3'(got.mf_toggle));
      compare_field("dock_on", 3'(want.dock_on), 3'(got.dock_on));
      compare_field("mf_value", 3'(want.mf_value), 3'(got.mf_value));
      compare_field("led_drive", 3'(want.led_drive), 3'(got.led_drive));
      compare_field("press_phase", want.press_phase, got.press_phase);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_button_raw = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_wake_pulse;
  logic        out_sleep_pulse;
  logic        out_mf_toggle_pulse;
  logic        out_dock_on;
  logic        out_mf_value;
  logic [1:0]  out_led_drive;
  logic [2:0]  out_press_phase;

  press_scoreboard sb;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_req = 0;
  int          hold_ack = 0;
  int          hold_left = 0;
  int          ticks_sent = 0;
  int unsigned cycle_count = 0;

  // stimulus shaping copies of the current settings
  logic        cur_pressed = 1'b0;
  int          cur_deb = 30;
  int          cur_short = 300000;
  int          cur_long = 5000000;
  int          cur_flash = 150000;

  power_button_press_classifier dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_button_raw       (in_button_raw),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_wake_pulse      (out_wake_pulse),
    .out_sleep_pulse     (out_sleep_pulse),
    .out_mf_toggle_pulse (out_mf_toggle_pulse),
    .out_dock_on         (out_dock_on),
    .out_mf_value        (out_mf_value),
    .out_led_drive       (out_led_drive),
    .out_press_phase     (out_press_phase)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("power_button_press_classifier: mismatch");
      $finish;
    end
  end

  // result side: check accepted beats, then pick next ready
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(press_result_t'{out_wake_pulse, out_sleep_pulse,
                                      out_mf_toggle_pulse, out_dock_on, out_mf_value,
                                      out_led_drive, out_press_phase});
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // one tick beat; valid stays high across back-to-back beats
  task automatic send_tick(input logic raw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_button_raw <= raw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_tick(raw);
    ticks_sent++;
  endtask

  // config beat; caller drops valid after the last one
  task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(input logic lvl, input int deb, input int shrt, input int lng,
                           input int flash, input logic imf);
    write_reg(CFG_UNMAPPED_LO, 24'($urandom));
    write_reg(CFG_PRESSED_LEVEL, {23'($urandom), lvl});
    write_reg(CFG_DEBOUNCE, {8'($urandom), 16'(deb)});
    write_reg(CFG_SHORT_PRESS, 24'(shrt));
    write_reg(CFG_LONG_PRESS, 24'(lng));
    write_reg(CFG_FLASH_STEP, 24'(flash));
    write_reg(CFG_INITIAL_MF, {23'($urandom), imf});
    write_reg(CFG_UNMAPPED_HI, 24'($urandom));
    cfg_valid   <= 1'b0;
    cur_pressed = lvl;
    cur_deb     = deb;
    cur_short   = shrt;
    cur_long    = lng;
    cur_flash   = flash;
  endtask

  // stop sending until every result beat is back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    drain();
    repeat (LATENCY_PAD) @(posedge clk);
  endtask

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  // bounded random length, kept short when settings are huge
  function automatic int pick(int lo, int hi);
    if (lo < 1) lo = 1;
    if (lo > 150) lo = 150;
    if (hi > lo + 150) hi = lo + 150;
    if (hi < lo) hi = lo;
    return $urandom_range(hi, lo);
  endfunction

  // contact bounce: glitches shorter than the debounce window
  task automatic chatter(input logic lvl);
    int n;
    n = (cur_deb > 1) ? cur_deb - 1 : 1;
    if (n > 12) n = 12;
    repeat ($urandom_range(3, 1)) begin
      repeat ($urandom_range(n, 1)) send_tick(~lvl);
      repeat ($urandom_range(n, 1)) send_tick(lvl);
    end
  endtask

  // one press and release, or a burst of noise
  task automatic press_cycle();
    int kind;
    int dur;
    logic p;
    p = cur_pressed;
    kind = $urandom_range(99);
    if (kind < 12) begin
      repeat ($urandom_range(8, 1)) send_tick(1'($urandom_range(1)));
    end else begin
      if ($urandom_range(1)) chatter(p);
      if (kind < 40) dur = pick(1, cur_short + cur_deb);
      else if (kind < 70) dur = pick(cur_short, cur_long + cur_deb);
      else dur = pick(cur_long, cur_long + cur_deb + 9 * (cur_flash + 1) + 8);
      repeat (dur) send_tick(p);
      if ($urandom_range(1)) chatter(~p);
      repeat (pick(cur_deb + 1, cur_deb + 15)) send_tick(~p);
    end
  endtask

  task automatic run_cycles(input int n);
    int target;
    target = ticks_sent + n;
    while (ticks_sent < target) press_cycle();
  endtask

  task automatic random_phase(input int send_pct, input int recv_pct);
    settle();
    configure(1'($urandom_range(1)), $urandom_range(6, 1), $urandom_range(40),
              $urandom_range(80), $urandom_range(4), 1'($urandom_range(1)));
    set_idle(send_pct, recv_pct);
    run_cycles(100);
  endtask

  initial begin
    int i;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // opening pattern: short press turns off, press powers on, long hold, bounce
    configure(1'b1, 1, 2, 6, 0, 1'b1);
    for (i = 23; i >= 0; i--) send_tick(OPENING_RAW[i]);

    settle();
    configure(1'b0, 2, 10, 25, 1, 1'b0);
    set_idle(0, 0);
    run_cycles(250);

    // sender gaps, with one full pause mid-phase
    settle();
    configure(1'b1, 4, 20, 45, 3, 1'b1);
    set_idle(82, 0);
    run_cycles(120);
    drain();
    run_cycles(130);

    // all zero counts: every timer acts as one tick
    settle();
    configure(1'b0, 0, 0, 0, 0, 1'b0);
    set_idle(0, 82);
    run_cycles(250);

    // short below debounce and long below short
    settle();
    configure(1'b1, 8, 5, 4, 5, 1'b1);
    set_idle(28, 28);
    run_cycles(250);

    // largest counts: debounce never completes in this stretch
    settle();
    configure(1'b1, 65535, 16777215, 16777215, 16777215, 1'b1);
    set_idle(0, 0);
    for (i = 0; i < 8; i++) repeat ($urandom_range(6, 1)) send_tick(1'(i));

    // long result stall so the input side backs up
    settle();
    configure(1'b0, 3, 15, 40, 2, 1'b0);
    set_idle(0, 0);
    run_cycles(60);
    hold_req <= hold_req + 1;
    run_cycles(190);

    random_phase(28, 28);
    random_phase(0, 0);
    random_phase(82, 0);
    random_phase(0, 82);

    settle();
    if (sb.failures == 0) begin
      $display("power_button_press_classifier: match");
    end else begin
      $display("power_button_press_classifier: mismatch");
    end
    $finish;
  end

endmodule
